@@ rtl/core/iq3_pkg.sv @@
// ----------------------------------------------------------------------------
// iq3_pkg
// Shared widths, types, grid table and saturating helpers for the IQ3_XXS
// dequantise-and-dot-product engine.
// ----------------------------------------------------------------------------
package iq3_pkg;

  // Field and datapath widths
  localparam int ACT_WIDTH = 16;              // activation width, 8 frac bits
  localparam int LANES     = 4;               // weights per beat
  localparam int D_W       = 32;              // block scale, Q7.24
  localparam int MAG_W     = 8;               // grid magnitude byte
  localparam int LS_W      = 5;               // odd group scale 2g+1
  localparam int LW_W      = 12;              // signed ls * w, |x| <= 31*62
  localparam int DW_W      = D_W + LW_W;      // d * ls * w
  localparam int PROD_W    = DW_W + ACT_WIDTH;
  localparam int ACC_W     = 64;
  localparam int EXT_W     = (PROD_W > ACC_W) ? PROD_W : ACC_W + 1;

  typedef logic signed [ACT_WIDTH-1:0] act_t;
  typedef logic signed [ACC_W-1:0]     acc_t;

  // Per-stage load enables shared by all lanes
  typedef struct packed {
    logic en_s1;
    logic en_s2;
    logic en_s3;
  } lane_ctl_t;

  // Beat sitting in front of the accumulator
  typedef struct packed {
    logic valid;
    logic last;
  } merge_ctl_t;

  typedef struct packed {
    logic ovf;
    acc_t sum;
  } sat_res_t;

  localparam acc_t ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam acc_t ACC_MIN = 64'sh8000_0000_0000_0000;

  // 256-entry grid: four 8-bit magnitudes per index, weight 0 in the low byte
  localparam logic [31:0] GRID_ROM [0:255] = '{
    32'h04040404, 32'h04040414, 32'h04040424, 32'h04040c0c,
    32'h04040c1c, 32'h04040c3e, 32'h04041404, 32'h04041414,
    32'h04041c0c, 32'h04042414, 32'h04043e1c, 32'h04043e2c,
    32'h040c040c, 32'h040c041c, 32'h040c0c04, 32'h040c0c14,
    32'h040c140c, 32'h040c142c, 32'h040c1c04, 32'h040c1c14,
    32'h040c240c, 32'h040c2c24, 32'h040c3e04, 32'h04140404,
    32'h04140414, 32'h04140424, 32'h04140c0c, 32'h04141404,
    32'h04141414, 32'h04141c0c, 32'h04141c1c, 32'h04141c3e,
    32'h04142c0c, 32'h04142c3e, 32'h04143e2c, 32'h041c040c,
    32'h041c043e, 32'h041c0c04, 32'h041c0c14, 32'h041c142c,
    32'h041c3e04, 32'h04240c1c, 32'h04241c3e, 32'h04242424,
    32'h04242c3e, 32'h04243e1c, 32'h04243e2c, 32'h042c040c,
    32'h042c043e, 32'h042c1c14, 32'h042c2c14, 32'h04341c2c,
    32'h04343424, 32'h043e0c04, 32'h043e0c24, 32'h043e0c34,
    32'h043e241c, 32'h043e340c, 32'h0c04040c, 32'h0c04041c,
    32'h0c040c04, 32'h0c040c14, 32'h0c04140c, 32'h0c04141c,
    32'h0c041c04, 32'h0c041c14, 32'h0c041c24, 32'h0c04243e,
    32'h0c042c04, 32'h0c0c0404, 32'h0c0c0414, 32'h0c0c0c0c,
    32'h0c0c1404, 32'h0c0c1414, 32'h0c14040c, 32'h0c14041c,
    32'h0c140c04, 32'h0c140c14, 32'h0c14140c, 32'h0c141c04,
    32'h0c143e14, 32'h0c1c0404, 32'h0c1c0414, 32'h0c1c1404,
    32'h0c1c1c0c, 32'h0c1c2434, 32'h0c1c3434, 32'h0c24040c,
    32'h0c24042c, 32'h0c242c04, 32'h0c2c1404, 32'h0c2c1424,
    32'h0c2c2434, 32'h0c2c3e0c, 32'h0c34042c, 32'h0c3e1414,
    32'h0c3e2404, 32'h14040404, 32'h14040414, 32'h14040c0c,
    32'h14040c1c, 32'h14041404, 32'h14041414, 32'h14041434,
    32'h14041c0c, 32'h14042414, 32'h140c040c, 32'h140c041c,
    32'h140c042c, 32'h140c0c04, 32'h140c0c14, 32'h140c140c,
    32'h140c1c04, 32'h140c341c, 32'h140c343e, 32'h140c3e04,
    32'h14140404, 32'h14140414, 32'h14140c0c, 32'h14140c3e,
    32'h14141404, 32'h14141414, 32'h14141c3e, 32'h14142404,
    32'h14142c2c, 32'h141c040c, 32'h141c0c04, 32'h141c0c24,
    32'h141c3e04, 32'h141c3e24, 32'h14241c2c, 32'h14242c1c,
    32'h142c041c, 32'h142c143e, 32'h142c240c, 32'h142c3e24,
    32'h143e040c, 32'h143e041c, 32'h143e0c34, 32'h143e242c,
    32'h1c04040c, 32'h1c040c04, 32'h1c040c14, 32'h1c04140c,
    32'h1c04141c, 32'h1c042c04, 32'h1c04342c, 32'h1c043e14,
    32'h1c0c0404, 32'h1c0c0414, 32'h1c0c1404, 32'h1c0c1c0c,
    32'h1c0c2424, 32'h1c0c2434, 32'h1c14040c, 32'h1c14041c,
    32'h1c140c04, 32'h1c14142c, 32'h1c142c14, 32'h1c143e14,
    32'h1c1c0c0c, 32'h1c1c1c1c, 32'h1c241c04, 32'h1c24243e,
    32'h1c243e14, 32'h1c2c0404, 32'h1c2c0434, 32'h1c2c1414,
    32'h1c2c2c2c, 32'h1c340c24, 32'h1c341c34, 32'h1c34341c,
    32'h1c3e1c1c, 32'h1c3e3404, 32'h24040424, 32'h24040c3e,
    32'h24041c2c, 32'h24041c3e, 32'h24042c1c, 32'h24042c3e,
    32'h240c3e24, 32'h24141404, 32'h24141c3e, 32'h24142404,
    32'h24143404, 32'h24143434, 32'h241c043e, 32'h241c242c,
    32'h24240424, 32'h24242c0c, 32'h24243424, 32'h242c142c,
    32'h242c241c, 32'h242c3e04, 32'h243e042c, 32'h243e0c04,
    32'h243e0c14, 32'h243e1c04, 32'h2c040c14, 32'h2c04240c,
    32'h2c043e04, 32'h2c0c0404, 32'h2c0c0434, 32'h2c0c1434,
    32'h2c0c2c2c, 32'h2c140c24, 32'h2c141c14, 32'h2c143e14,
    32'h2c1c0414, 32'h2c1c2c1c, 32'h2c240c04, 32'h2c24141c,
    32'h2c24143e, 32'h2c243e14, 32'h2c2c0414, 32'h2c2c1c0c,
    32'h2c342c04, 32'h2c3e1424, 32'h2c3e2414, 32'h34041424,
    32'h34042424, 32'h34042434, 32'h34043424, 32'h340c140c,
    32'h340c340c, 32'h34140c3e, 32'h34143424, 32'h341c1c04,
    32'h341c1c34, 32'h34242424, 32'h342c042c, 32'h342c2c14,
    32'h34341c1c, 32'h343e041c, 32'h343e140c, 32'h3e04041c,
    32'h3e04042c, 32'h3e04043e, 32'h3e040c04, 32'h3e041c14,
    32'h3e042c14, 32'h3e0c1434, 32'h3e0c2404, 32'h3e140c14,
    32'h3e14242c, 32'h3e142c14, 32'h3e1c0404, 32'h3e1c0c2c,
    32'h3e1c1c1c, 32'h3e1c3404, 32'h3e24140c, 32'h3e24240c,
    32'h3e2c0404, 32'h3e2c0414, 32'h3e2c1424, 32'h3e341c04
  };

  // Saturating 64-bit add, flags a clamp
  function automatic sat_res_t sat_add(input acc_t a, input acc_t b);
    logic signed [ACC_W:0] s;
    sat_res_t r;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    r.ovf = s[ACC_W] ^ s[ACC_W-1];
    if (r.ovf) begin
      r.sum = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      r.sum = s[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/iq3_if.sv @@
// ----------------------------------------------------------------------------
// iq3 channel interfaces
// Valid/ready channels for weight beats in and row sums out.
// ----------------------------------------------------------------------------
interface iq3_in_if;
  import iq3_pkg::*;

  logic              valid;
  logic              ready;
  logic signed [31:0] block_scale;
  logic [31:0]       scale_sign_word;
  logic [7:0]        grid_index;
  logic [2:0]        position;
  act_t              act_a;
  act_t              act_b;
  act_t              act_c;
  act_t              act_d;
  logic              last;

  modport source (
    output valid, block_scale, scale_sign_word, grid_index, position,
           act_a, act_b, act_c, act_d, last,
    input  ready
  );
  modport sink (
    input  valid, block_scale, scale_sign_word, grid_index, position,
           act_a, act_b, act_c, act_d, last,
    output ready
  );
endinterface

interface iq3_out_if;
  import iq3_pkg::*;

  logic valid;
  logic ready;
  acc_t row_sum;
  logic saturated;

  modport source (output valid, row_sum, saturated, input ready);
  modport sink   (input valid, row_sum, saturated, output ready);
endinterface

@@ rtl/core/iq3_lane.sv @@
// ----------------------------------------------------------------------------
// iq3_lane
// One weight lane: signed ls*w, times block scale, times activation, then
// clamp of the product to 64 bits. Three register stages.
// ----------------------------------------------------------------------------
module iq3_lane (
  input  logic                        clk,
  input  iq3_pkg::lane_ctl_t          ctl,
  input  logic [iq3_pkg::MAG_W-1:0]   mag,
  input  logic                        neg,
  input  logic [iq3_pkg::LS_W-1:0]    ls,
  input  iq3_pkg::act_t               act,
  input  logic signed [iq3_pkg::D_W-1:0] d_s1,
  output iq3_pkg::acc_t               prod,
  output logic                        prod_ovf
);
  import iq3_pkg::*;

  localparam logic signed [EXT_W-1:0] P_MAX = EXT_W'(ACC_MAX);
  localparam logic signed [EXT_W-1:0] P_MIN = EXT_W'(ACC_MIN);

  logic signed [LW_W-1:0]   ls_s, w_s, lw_nxt, lw_r;
  act_t                     act1_r, act2_r;
  logic signed [DW_W-1:0]   dw_r;
  logic signed [PROD_W-1:0] p_full;
  logic signed [EXT_W-1:0]  p_ext;
  acc_t                     prod_r;
  logic                     ovf_r;

  // Stage 1: signed weight times odd group scale
  always_comb begin
    ls_s   = LW_W'(signed'({1'b0, ls}));
    w_s    = neg ? -LW_W'(signed'({1'b0, mag})) : LW_W'(signed'({1'b0, mag}));
    lw_nxt = ls_s * w_s;
  end

  always_ff @(posedge clk) begin
    if (ctl.en_s1) begin
      lw_r   <= lw_nxt;
      act1_r <= act;
    end
  end

  // Stage 2: block scale
  always_ff @(posedge clk) begin
    if (ctl.en_s2) begin
      dw_r   <= DW_W'(d_s1) * DW_W'(lw_r);
      act2_r <= act1_r;
    end
  end

  // Stage 3: activation product, clamped to the accumulator range
  always_comb begin
    p_full = PROD_W'(dw_r) * PROD_W'(act2_r);
    p_ext  = EXT_W'(p_full);
  end

  always_ff @(posedge clk) begin
    if (ctl.en_s3) begin
      if (p_ext > P_MAX) begin
        prod_r <= ACC_MAX;
        ovf_r  <= 1'b1;
      end else if (p_ext < P_MIN) begin
        prod_r <= ACC_MIN;
        ovf_r  <= 1'b1;
      end else begin
        prod_r <= p_ext[ACC_W-1:0];
        ovf_r  <= 1'b0;
      end
    end
  end

  assign prod     = prod_r;
  assign prod_ovf = ovf_r;

endmodule

@@ rtl/core/iq3_merge.sv @@
// ----------------------------------------------------------------------------
// iq3_merge
// Folds the four lane products into the saturating row accumulator, two ordered
// adds per cycle when not stalled, and holds the row result in the output register.
// ----------------------------------------------------------------------------
module iq3_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  iq3_pkg::merge_ctl_t  s3,
  input  iq3_pkg::acc_t        prod [iq3_pkg::LANES],
  input  logic [iq3_pkg::LANES-1:0] prod_ovf,
  output logic                 take,
  iq3_out_if.source            out_ch
);
  import iq3_pkg::*;

  acc_t     acc_r, acc_nxt;
  logic     seen_r, seen_nxt;
  logic     phase_r, phase_nxt;
  logic     out_valid_r, out_valid_nxt;
  acc_t     out_sum_r, out_sum_nxt;
  logic     out_sat_r, out_sat_nxt;
  acc_t     pa, pb;
  logic     pa_ovf, pb_ovf;
  sat_res_t r1, r2;
  logic     flags;
  logic     out_free;

  // Phase 0 takes weights 0 and 1, phase 1 weights 2 and 3
  always_comb begin
    pa     = phase_r ? prod[2] : prod[0];
    pb     = phase_r ? prod[3] : prod[1];
    pa_ovf = phase_r ? prod_ovf[2] : prod_ovf[0];
    pb_ovf = phase_r ? prod_ovf[3] : prod_ovf[1];
    r1     = sat_add(acc_r, pa);
    r2     = sat_add(r1.sum, pb);
    flags  = pa_ovf | pb_ovf | r1.ovf | r2.ovf;
  end

  assign out_free = !out_valid_r || out_ch.ready;
  assign take     = s3.valid && phase_r && (!s3.last || out_free);

  // Accumulator and emit control
  always_comb begin
    acc_nxt       = acc_r;
    seen_nxt      = seen_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_sum_nxt   = out_sum_r;
    out_sat_nxt   = out_sat_r;
    if (s3.valid && !phase_r) begin
      acc_nxt   = r2.sum;
      seen_nxt  = seen_r | flags;
      phase_nxt = 1'b1;
    end else if (take) begin
      phase_nxt = 1'b0;
      if (s3.last) begin
        out_valid_nxt = 1'b1;
        out_sum_nxt   = r2.sum;
        out_sat_nxt   = seen_r | flags;
        acc_nxt       = '0;
        seen_nxt      = 1'b0;
      end else begin
        acc_nxt  = r2.sum;
        seen_nxt = seen_r | flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      seen_r      <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      seen_r      <= seen_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_sum_r <= out_sum_nxt;
    out_sat_r <= out_sat_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_sum   = out_sum_r;
  assign out_ch.saturated = out_sat_r;

endmodule

@@ rtl/core/iq3_xxs_dequant_dot.sv @@
// ----------------------------------------------------------------------------
// iq3_xxs_dequant_dot
// IQ3_XXS dequantise-and-dot-product engine: four weight lanes and a
// saturating row accumulator.
// ----------------------------------------------------------------------------
// Usage
//   in_ch carries one beat per grid byte: block scale (Q7.24), the group's
//   scale/sign word, grid index, slot position, four activations (8 frac
//   bits) and last. A beat is taken when valid and ready are both high.
//   out_ch carries one beat per row, produced by the input beat marked
//   last: row_sum with 32 fractional bits and the sticky saturated flag.
//   The last beat passes the lane registers and both accumulator phases
//   before its sum enters the output register. The accumulator takes
//   one beat at a time, four products in order, two saturating adds a cycle.
//   Lanes run three stages: ls*w, times block scale, times activation.
//   Reset clears the accumulator, the saturation flag and all valid bits.
//   When out_ch stalls, the finished sum waits in the output register and
//   further beats keep flowing until the next last beat reaches the
//   accumulator; then in_ch.ready falls as the lanes fill up.
// ----------------------------------------------------------------------------
module iq3_xxs_dequant_dot (
  input  logic      clk,
  input  logic      rst_n,
  iq3_in_if.sink    in_ch,
  iq3_out_if.source out_ch
);
  import iq3_pkg::*;

  lane_ctl_t           ctl;
  merge_ctl_t          s3;
  logic                take;
  logic                s1_valid_r, s2_valid_r, s3_valid_r;
  logic                s1_last_r, s2_last_r, s3_last_r;
  logic signed [D_W-1:0] d_r;
  logic [31:0]         grid;
  logic [31:0]         word;
  logic [6:0]          field;
  logic [7:0]          signs;
  logic [LS_W-1:0]     ls;
  act_t                act_in [LANES];
  acc_t                prod [LANES];
  logic [LANES-1:0]    prod_ovf;
  logic [LANES-1:0]    neg;

  // Stall chain: each stage loads when it is empty or drains
  always_comb begin
    ctl.en_s3 = !s3_valid_r || take;
    ctl.en_s2 = !s2_valid_r || ctl.en_s3;
    ctl.en_s1 = !s1_valid_r || ctl.en_s2;
  end

  assign in_ch.ready = ctl.en_s1;

  // Decode: grid lookup, sign field with parity bit, odd group scale
  always_comb begin
    word = in_ch.scale_sign_word;
    grid = GRID_ROM[in_ch.grid_index];
    ls   = {word[31:28], 1'b1};
    case (in_ch.position[2:1])
      2'd0:    field = word[6:0];
      2'd1:    field = word[13:7];
      2'd2:    field = word[20:14];
      2'd3:    field = word[27:21];
      default: field = word[6:0];
    endcase
    signs = {^field, field};
    for (int j = 0; j < LANES; j++) begin
      neg[j] = signs[{in_ch.position[0], 2'(j)}];
    end
    act_in[0] = in_ch.act_a;
    act_in[1] = in_ch.act_b;
    act_in[2] = in_ch.act_c;
    act_in[3] = in_ch.act_d;
  end

  // Stage valid and last flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      if (ctl.en_s1) s1_valid_r <= in_ch.valid;
      if (ctl.en_s2) s2_valid_r <= s1_valid_r;
      if (ctl.en_s3) s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_s1) begin
      s1_last_r <= in_ch.last;
      d_r       <= in_ch.block_scale;
    end
    if (ctl.en_s2) s2_last_r <= s1_last_r;
    if (ctl.en_s3) s3_last_r <= s2_last_r;
  end

  // Weight lanes
  for (genvar j = 0; j < LANES; j++) begin : g_lane
    iq3_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .mag      (grid[MAG_W*j +: MAG_W]),
      .neg      (neg[j]),
      .ls       (ls),
      .act      (act_in[j]),
      .d_s1     (d_r),
      .prod     (prod[j]),
      .prod_ovf (prod_ovf[j])
    );
  end

  assign s3.valid = s3_valid_r;
  assign s3.last  = s3_last_r;

  // Row accumulator and result register
  iq3_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .s3       (s3),
    .prod     (prod),
    .prod_ovf (prod_ovf),
    .take     (take),
    .out_ch   (out_ch)
  );

endmodule
